/* design/triangular_matrix_expression_macros.svh */
// Assertion macros for the triangular matrix expression block.
`ifndef TRIANGULAR_MATRIX_EXPRESSION_MACROS_SVH
`define TRIANGULAR_MATRIX_EXPRESSION_MACROS_SVH
`ifndef SYNTH
`define TME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TME_ASSERT_IMP(lbl, ante, cons, msg)
`define TME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/tme_pkg.sv */
// Shared constants and types of the triangular matrix expression block.
`timescale 1ns / 1ps
package tme_pkg;
  localparam int MAX_DIM_DEF = 64;
  localparam int SIZE_W = 7;
  localparam int IDX_W = 6;
  localparam int VAL_W = 16;
  localparam int SUM_W = 39;
  localparam int RES_W = 61;
  localparam int OUT_W = 64;
  localparam int PROD_W = SUM_W + VAL_W;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic phase2;
  } tme_tag_t;
endpackage

/* design/tme_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/tme_seq.sv */
// Sequencer that walks both matrix products and issues store addresses.
`timescale 1ns / 1ps
module tme_seq #(
  parameter int IW = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IW-1:0]     n_last,
  output logic              busy,
  output logic              done,
  output logic [2*IW-1:0]   a_raddr,
  output logic [2*IW-1:0]   b_raddr,
  output logic [2*IW-1:0]   s_raddr,
  output logic [2*IW-1:0]   dest_addr,
  output tme_pkg::tme_tag_t tag
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1 = 3'd1;
  localparam logic [2:0] S_D1 = 3'd2;
  localparam logic [2:0] S_P2 = 3'd3;
  localparam logic [2:0] S_D2 = 3'd4;

  logic [2:0]    state;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] k;
  logic          term;
  logic [1:0]    drain;

  assign busy = (state != S_IDLE);
  assign done = (state == S_D2) && (drain == 2'd2);
  assign a_raddr = term ? {k, j} : {k, i};
  assign b_raddr = (state == S_P2) ? {j, k} : (term ? {i, k} : {k, j});
  assign s_raddr = {i, k};
  assign dest_addr = {i, j};

  always_comb begin
    tag.valid = (state == S_P1) || (state == S_P2);
    tag.phase2 = (state == S_P2);
    if (state == S_P2) begin
      tag.first = (k == '0);
      tag.last = (k == n_last);
    end else begin
      tag.first = !term && (k == '0);
      tag.last = term && (k == j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      j <= '0;
      k <= '0;
      term <= 1'b0;
      drain <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
          term <= 1'b0;
          drain <= '0;
          if (start) begin
            state <= S_P1;
          end
        end
        S_P1: begin
          if (!term) begin
            if (k == i) begin
              term <= 1'b1;
              k <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end else if (k == j) begin
            term <= 1'b0;
            k <= '0;
            if (j == n_last) begin
              j <= '0;
              if (i == n_last) begin
                i <= '0;
                state <= S_D1;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_D1: begin
          drain <= drain + 1'b1;
          if (drain == 2'd2) begin
            drain <= '0;
            state <= S_P2;
          end
        end
        S_P2: begin
          if (k == n_last) begin
            k <= '0;
            if (j == n_last) begin
              j <= '0;
              if (i == n_last) begin
                i <= '0;
                state <= S_D2;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_D2: begin
          drain <= drain + 1'b1;
          if (drain == 2'd2) begin
            drain <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* design/tme_mac.sv */
// Shared multiply-accumulate unit used by both matrix products.
`timescale 1ns / 1ps
module tme_mac #(
  parameter int AW = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tme_pkg::tme_tag_t                tag_in,
  input  logic [AW-1:0]                    dest_in,
  input  logic [tme_pkg::VAL_W-1:0]        a_rd,
  input  logic [tme_pkg::VAL_W-1:0]        b_rd,
  input  logic [tme_pkg::SUM_W-1:0]        s_rd,
  output logic                             s_we,
  output logic                             c_we,
  output logic [AW-1:0]                    wr_addr,
  output logic [tme_pkg::RES_W-1:0]        wr_data
);
  tme_pkg::tme_tag_t                  tag1;
  tme_pkg::tme_tag_t                  tag2;
  logic [AW-1:0]                      dest1;
  logic [AW-1:0]                      dest2;
  logic signed [tme_pkg::SUM_W-1:0]   x_op;
  logic signed [tme_pkg::VAL_W-1:0]   y_op;
  logic signed [tme_pkg::PROD_W-1:0]  prod_next;
  logic signed [tme_pkg::PROD_W-1:0]  prod;
  logic [tme_pkg::RES_W-1:0]          prod_ext;
  logic [tme_pkg::RES_W-1:0]          acc;
  logic [tme_pkg::RES_W-1:0]          acc_next;

  always_comb begin
    x_op = tag1.phase2 ? s_rd
                       : {{(tme_pkg::SUM_W - tme_pkg::VAL_W){a_rd[tme_pkg::VAL_W-1]}}, a_rd};
    y_op = b_rd;
    prod_next = x_op * y_op;
    prod_ext = {{(tme_pkg::RES_W - tme_pkg::PROD_W){prod[tme_pkg::PROD_W-1]}}, prod};
    acc_next = tag2.first ? prod_ext : acc + prod_ext;
  end

  assign s_we = tag2.valid && tag2.last && !tag2.phase2;
  assign c_we = tag2.valid && tag2.last && tag2.phase2;
  assign wr_addr = dest2;
  assign wr_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
    end
    dest1 <= dest_in;
    dest2 <= dest1;
    prod <= prod_next;
    if (tag2.valid) begin
      acc <= acc_next;
    end
  end
endmodule

/* design/triangular_matrix_expression.sv */
// Top level of the triangular matrix expression block.
// Computes C = (A^T*B + B*A)*B^T for n-by-n Q8.8 matrices, A upper triangular,
// with exact Q40.24 results. Loads are written as they are accepted; a read
// returns its transaction from the output register after the read state; no
// new command is taken while a result waits on the output. A compute runs on
// one shared multiplier and accumulator, one product per cycle, and holds off
// new commands until it is done.
// After reset the result store is cleared one entry per cycle, all 4096
// entries at the default size, and no command is accepted meanwhile.
`timescale 1ns / 1ps
`include "triangular_matrix_expression_macros.svh"
module triangular_matrix_expression #(
  parameter int MAX_DIM = tme_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tme_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic [tme_pkg::IDX_W-1:0]         row,
  input  logic [tme_pkg::IDX_W-1:0]         col,
  input  logic signed [tme_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tme_pkg::OUT_W-1:0]  result_value,
  output logic                              status
);
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = 2 * IW;
  localparam int DEPTH = 2 ** AW;
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = (NW > tme_pkg::IDX_W) ? NW : tme_pkg::IDX_W;
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]                  state;
  logic [tme_pkg::SIZE_W-1:0]  size_reg;
  logic [AW-1:0]               clr_addr;
  logic                        in_range_q;
  logic [8:0]                  size_wide;
  logic [NW-1:0]               n_val;
  logic [IW-1:0]               n_last;
  logic                        in_range;
  logic                        accept;
  logic [AW-1:0]               in_addr;
  logic                        seq_busy;
  logic                        seq_done;
  logic [AW-1:0]               a_raddr;
  logic [AW-1:0]               b_raddr;
  logic [AW-1:0]               s_raddr;
  logic [AW-1:0]               dest_addr;
  tme_pkg::tme_tag_t           tag;
  logic [tme_pkg::VAL_W-1:0]   a_rd;
  logic [tme_pkg::VAL_W-1:0]   b_rd;
  logic [tme_pkg::SUM_W-1:0]   s_rd;
  logic [tme_pkg::RES_W-1:0]   c_rd;
  logic                        s_we;
  logic                        c_we;
  logic [AW-1:0]               wr_addr;
  logic [tme_pkg::RES_W-1:0]   wr_data;
  logic                        c_ram_we;
  logic [AW-1:0]               c_ram_waddr;
  logic [tme_pkg::RES_W-1:0]   c_ram_wdata;

  always_comb begin
    size_wide = 9'(size_reg);
    if (size_reg == '0) begin
      n_val = NW'(1);
    end else if (size_wide > 9'(MAX_DIM)) begin
      n_val = NW'(MAX_DIM);
    end else begin
      n_val = NW'(size_reg);
    end
  end

  assign n_last = IW'(n_val - NW'(1));
  assign in_range = (CW'(row) < CW'(n_val)) && (CW'(col) < CW'(n_val));
  assign in_addr = {IW'(row), IW'(col)};
  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  assign c_ram_we = (state == ST_CLEAR) || c_we;
  assign c_ram_waddr = (state == ST_CLEAR) ? clr_addr : wr_addr;
  assign c_ram_wdata = (state == ST_CLEAR) ? '0 : wr_data;

  tme_ram #(.WIDTH(tme_pkg::VAL_W), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .we(accept && (cmd == tme_pkg::CMD_LOAD_A) && in_range),
    .waddr(in_addr), .wdata(value), .raddr(a_raddr), .rdata(a_rd)
  );

  tme_ram #(.WIDTH(tme_pkg::VAL_W), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .we(accept && (cmd == tme_pkg::CMD_LOAD_B) && in_range),
    .waddr(in_addr), .wdata(value), .raddr(b_raddr), .rdata(b_rd)
  );

  tme_ram #(.WIDTH(tme_pkg::SUM_W), .DEPTH(DEPTH)) u_s_ram (
    .clk(clk), .we(s_we), .waddr(wr_addr), .wdata(wr_data[tme_pkg::SUM_W-1:0]),
    .raddr(s_raddr), .rdata(s_rd)
  );

  tme_ram #(.WIDTH(tme_pkg::RES_W), .DEPTH(DEPTH)) u_c_ram (
    .clk(clk), .we(c_ram_we), .waddr(c_ram_waddr), .wdata(c_ram_wdata),
    .raddr(in_addr), .rdata(c_rd)
  );

  tme_seq #(.IW(IW)) u_seq (
    .clk(clk), .rst(rst),
    .start(accept && (cmd == tme_pkg::CMD_COMPUTE)),
    .n_last(n_last), .busy(seq_busy), .done(seq_done),
    .a_raddr(a_raddr), .b_raddr(b_raddr), .s_raddr(s_raddr),
    .dest_addr(dest_addr), .tag(tag)
  );

  tme_mac #(.AW(AW)) u_mac (
    .clk(clk), .rst(rst), .tag_in(tag), .dest_in(dest_addr),
    .a_rd(a_rd), .b_rd(b_rd), .s_rd(s_rd),
    .s_we(s_we), .c_we(c_we), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      size_reg <= tme_pkg::SIZE_RESET;
      clr_addr <= '0;
      out_valid <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            in_range_q <= in_range;
            if (cmd == tme_pkg::CMD_COMPUTE) begin
              state <= ST_COMP;
            end else if (cmd == tme_pkg::CMD_READ) begin
              state <= ST_READ;
            end
          end
        end
        ST_COMP: begin
          if (seq_done) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      result_value <= in_range_q
          ? {{(tme_pkg::OUT_W - tme_pkg::RES_W){c_rd[tme_pkg::RES_W-1]}}, c_rd}
          : '0;
      status <= !in_range_q;
    end
  end

  `TME_ASSERT_IMP(a_status_zero, out_valid && status, result_value == '0, "beyond-size read not zero")
  `TME_ASSERT_IMP(a_busy_blocks, seq_busy, !in_ready, "command accepted during compute")
  `TME_ASSERT_NEXT(a_read_out, state == ST_READ, out_valid, "read produced no transaction")
endmodule
